### rtl/blr_pkg.sv
// Shared constants for the line rasterizer: command codes and color width.
package blr_pkg;

    // Command codes carried by an input item
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // RGB565 color width
    localparam int COLOR_BITS = 16;

endpackage

### rtl/blr_if.sv
// Valid/ready stream interfaces for the rasterizer command and pixel channels.
interface blr_cmd_if
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 9
) ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] pen_color;

    modport source (
        output valid, command, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );
    modport sink (
        input  valid, command, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

interface blr_pix_if
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 9
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

### rtl/blr_line_setup.sv
// Line setup: picks the major axis, orders the endpoints and forms the deltas.
module blr_line_setup
#(
    parameter int COORD_BITS = 9
)
(
    input  logic [COORD_BITS-1:0] a_x,
    input  logic [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-1:0] b_x,
    input  logic [COORD_BITS-1:0] b_y,
    output logic                  steep,
    output logic [COORD_BITS-1:0] major_pos,
    output logic [COORD_BITS-1:0] major_end,
    output logic [COORD_BITS-1:0] minor_pos,
    output logic                  minor_down,
    output logic [COORD_BITS-1:0] major_delta,
    output logic [COORD_BITS-1:0] minor_delta
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] m0;
    logic [COORD_BITS-1:0] n0;
    logic [COORD_BITS-1:0] m1;
    logic [COORD_BITS-1:0] n1;

    always_comb
    begin
        // absolute extents on both axes
        dx = (a_x >= b_x) ? (a_x - b_x) : (b_x - a_x);
        dy = (a_y >= b_y) ? (a_y - b_y) : (b_y - a_y);
        steep = (dy > dx);

        // map onto major/minor axes
        if (steep)
        begin
            m0 = a_y;
            n0 = a_x;
            m1 = b_y;
            n1 = b_x;
        end
        else
        begin
            m0 = a_x;
            n0 = a_y;
            m1 = b_x;
            n1 = b_y;
        end

        // walk with rising major coordinate
        if (m0 > m1)
        begin
            major_pos = m1;
            major_end = m0;
            minor_pos = n1;
            minor_down = (n1 > n0);
            major_delta = m0 - m1;
            minor_delta = (n1 >= n0) ? (n1 - n0) : (n0 - n1);
        end
        else
        begin
            major_pos = m0;
            major_end = m1;
            minor_pos = n0;
            minor_down = (n0 > n1);
            major_delta = m1 - m0;
            minor_delta = (n0 >= n1) ? (n0 - n1) : (n1 - n0);
        end
    end

endmodule

### rtl/bresenham_line_rasterizer_unit.sv
// Bresenham line rasterizer top level: line state, stepping and pixel output register.
// A step item's pixel is in the output register in the cycle after its acceptance.
// Throughput: one item per cycle unless the output register stalls; the error-term
// update per step and the output register set the rate. A start item gives no pixel.
// Input ready follows the output register: high when it is empty or being drained.
// Reset (rst_n, asynchronous, active low) clears the line state and the output valid.
module bresenham_line_rasterizer_unit
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 9
)
(
    input  logic           clk,
    input  logic           rst_n,
    blr_cmd_if.sink        cmd,
    blr_pix_if.source      pix
);

    localparam int ERR_BITS = COORD_BITS + 2;

    // line state
    logic                       active_reg,      active_next;
    logic                       steep_reg,       steep_next;
    logic [COORD_BITS-1:0]      major_pos_reg,   major_pos_next;
    logic [COORD_BITS-1:0]      major_end_reg,   major_end_next;
    logic [COORD_BITS-1:0]      minor_pos_reg,   minor_pos_next;
    logic                       minor_down_reg,  minor_down_next;
    logic [COORD_BITS-1:0]      major_delta_reg, major_delta_next;
    logic [COORD_BITS-1:0]      minor_delta_reg, minor_delta_next;
    logic signed [ERR_BITS-1:0] error_reg,       error_next;
    logic [COLOR_BITS-1:0]      color_reg,       color_next;

    // output register
    logic                       out_valid_reg,   out_valid_next;
    logic [COORD_BITS-1:0]      out_x_reg,       out_x_next;
    logic [COORD_BITS-1:0]      out_y_reg,       out_y_next;
    logic [COLOR_BITS-1:0]      out_color_reg,   out_color_next;
    logic                       out_last_reg,    out_last_next;

    // setup results
    logic                       su_steep;
    logic [COORD_BITS-1:0]      su_major_pos;
    logic [COORD_BITS-1:0]      su_major_end;
    logic [COORD_BITS-1:0]      su_minor_pos;
    logic                       su_minor_down;
    logic [COORD_BITS-1:0]      su_major_delta;
    logic [COORD_BITS-1:0]      su_minor_delta;

    logic                       in_ready;
    logic                       in_accept;
    logic                       do_step;
    logic                       at_end;
    logic signed [ERR_BITS-1:0] err_sum;

    blr_line_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .a_x         (cmd.start_x),
        .a_y         (cmd.start_y),
        .b_x         (cmd.end_x),
        .b_y         (cmd.end_y),
        .steep       (su_steep),
        .major_pos   (su_major_pos),
        .major_end   (su_major_end),
        .minor_pos   (su_minor_pos),
        .minor_down  (su_minor_down),
        .major_delta (su_major_delta),
        .minor_delta (su_minor_delta)
    );

    // handshake
    assign in_ready  = !out_valid_reg || pix.ready;
    assign in_accept = cmd.valid && in_ready;
    assign do_step   = in_accept && (cmd.command == CMD_STEP) && active_reg;
    assign at_end    = (major_pos_reg == major_end_reg);
    assign err_sum   = error_reg + $signed({2'b00, minor_delta_reg});

    assign cmd.ready       = in_ready;
    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last_pixel  = out_last_reg;

    // line state update
    always_comb
    begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        minor_down_next  = minor_down_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_next       = error_reg;
        color_next       = color_reg;

        if (in_accept && (cmd.command == CMD_START))
        begin
            active_next      = 1'b1;
            steep_next       = su_steep;
            major_pos_next   = su_major_pos;
            major_end_next   = su_major_end;
            minor_pos_next   = su_minor_pos;
            minor_down_next  = su_minor_down;
            major_delta_next = su_major_delta;
            minor_delta_next = su_minor_delta;
            error_next       = -$signed({2'b00, (su_major_delta >> 1)});
            color_next       = cmd.pen_color;
        end
        else if (do_step)
        begin
            // error positive: move minor axis and take back one major delta
            if (!err_sum[ERR_BITS-1] && (err_sum != '0))
            begin
                minor_pos_next = minor_down_reg ? (minor_pos_reg - 1'b1)
                                                : (minor_pos_reg + 1'b1);
                error_next     = err_sum - $signed({2'b00, major_delta_reg});
            end
            else
            begin
                error_next = err_sum;
            end

            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
            end
        end
    end

    // output register load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (do_step)
        begin
            out_valid_next = 1'b1;
            out_x_next     = steep_reg ? minor_pos_reg : major_pos_reg;
            out_y_next     = steep_reg ? major_pos_reg : minor_pos_reg;
            out_color_next = color_reg;
            out_last_next  = at_end;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            minor_down_reg  <= 1'b0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            error_reg       <= '0;
            color_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            steep_reg       <= steep_next;
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            minor_down_reg  <= minor_down_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            error_reg       <= error_next;
            color_reg       <= color_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // pixel payload
    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // a start item always leaves a line in progress
    a_start_activates: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (cmd.command == CMD_START) |=> active_reg)
        else $error("start item did not activate line");

    // the step on the final endpoint ends the line and flags last
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        do_step && at_end |=> !active_reg && pix.valid && pix.last_pixel)
        else $error("final pixel did not end line");

    // error term stays non-positive between steps
    a_error_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (error_reg <= 0))
        else $error("error term went positive");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cmd.ready)
        else $error("input stalled with empty output register");
`endif

endmodule
